// File: design/zfla_pkg.sv
package zfla_pkg;

    // Design defaults
    localparam int ZONES_DEF   = 64;
    localparam int CAMERAS_DEF = 4;

    // Fixed field and accumulator widths
    localparam int DEPTH_W = 15;
    localparam int DIST_W  = 16;
    localparam int FILL_W  = 10;
    localparam int VALID_W = 7;
    localparam int CSUM_W  = 16;
    localparam int FSUM_W  = 12;
    localparam int ACNT_W  = 3;
    localparam int MASK_W  = 4;
    localparam int CAM_W   = 2;
    localparam int CONF_W  = 7;

    // Shared divider: quotient never exceeds full scale, so ten quotient bits
    localparam int DIV_QW = 10;
    localparam int DIV_NW = 25;
    localparam int DIV_DW = DEPTH_W;
    localparam int DIV_SW = $clog2(DIV_QW);

    localparam logic [FILL_W-1:0]  FULL_SCALE   = 10'd1000;
    localparam logic [CONF_W-1:0]  CONF_PER_CAM = 7'd25;
    localparam logic [DEPTH_W-1:0] DEPTH_RST    = 15'd1000;
    localparam logic [MASK_W-1:0]  PRESENT_RST  = 4'hF;

    // Configuration register indexes
    localparam logic REG_DEPTH   = 1'b0;
    localparam logic REG_PRESENT = 1'b1;

    // Camera health codes
    localparam logic [1:0] HEALTH_OK       = 2'd0;
    localparam logic [1:0] HEALTH_DEGRADED = 2'd1;
    localparam logic [1:0] HEALTH_ABSENT   = 2'd2;

    typedef struct packed {
        logic [DIST_W-1:0] zone_mm;
        logic              read_failed;
    } t_in_beat;

    typedef struct packed {
        logic               is_summary;
        logic [CAM_W-1:0]   camera;
        logic [FILL_W-1:0]  fill_x10;
        logic [VALID_W-1:0] good_zones;
        logic [1:0]         health;
        logic [MASK_W-1:0]  status_mask;
        logic [FILL_W-1:0]  spread_x10;
        logic [CONF_W-1:0]  confidence;
        logic               last;
    } t_out_beat;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quotient;
    } t_div_rsp;

endpackage

// File: design/zone_fill_level_aggregator_unit.sv
// Zone fill level aggregator. Zone distances arrive one per input beat, ZONES
// beats per camera and CAMERAS cameras per frame. A valid reading (non-zero and
// not above twice the depth) is handled from accept to the next accept in steps:
// form (depth-d)*1000, wait on the shared radix-2 divider, then accumulate and
// return to idle. A dropped reading skips the divide. The last zone of a camera
// adds the mean divide on the same divider (skipped for an absent camera or one
// with no valid zones) and a step to issue the camera beat; the last camera adds
// the frame mean divide (skipped with no active camera) and the summary beat.
// Input stall is high for all of that time, and longer while a new beat cannot
// be loaded because the output register is still held; a camera beat that
// waits in the output register does not block the next zone.
// depth_mm and present_mask are written on the plain write port; the user must
// write them only while idle, as the block itself does not enforce it.
module zone_fill_level_aggregator_unit #(
    parameter int ZONES   = zfla_pkg::ZONES_DEF,
    parameter int CAMERAS = zfla_pkg::CAMERAS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  zfla_pkg::t_in_beat           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output zfla_pkg::t_out_beat          o_out_data,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [zfla_pkg::DEPTH_W-1:0] i_cfg_data
);

    localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int CW = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ZDIV, S_ZEND, S_CDIV, S_CRES, S_FSTART, S_FDIV
    } t_state;

    t_state                             r_state;
    logic                               r_fres;

    logic [zfla_pkg::DEPTH_W-1:0]       r_depth;
    logic [zfla_pkg::MASK_W-1:0]        r_present_mask;

    logic [ZW-1:0]                      r_zone;
    logic [CW-1:0]                      r_cam;
    logic [zfla_pkg::CSUM_W-1:0]        r_cam_sum;
    logic [zfla_pkg::VALID_W-1:0]       r_cam_valid;
    logic                               r_cam_failed;
    logic                               r_present;
    logic [zfla_pkg::FSUM_W-1:0]        r_frame_sum;
    logic [zfla_pkg::FILL_W-1:0]        r_frame_min;
    logic [zfla_pkg::FILL_W-1:0]        r_frame_max;
    logic [zfla_pkg::ACNT_W-1:0]        r_act_cnt;
    logic [zfla_pkg::MASK_W-1:0]        r_act_mask;

    logic [zfla_pkg::DEPTH_W-1:0]       r_diff;
    logic [zfla_pkg::FILL_W-1:0]        r_fill;

    logic                               r_out_valid;
    zfla_pkg::t_out_beat                r_out_data;

    zfla_pkg::t_div_req                 w_div_req;
    zfla_pkg::t_div_rsp                 w_div_rsp;

    zfla_pkg::t_out_beat                w_cam_beat;
    zfla_pkg::t_out_beat                w_sum_beat;

    logic                               w_accept;
    logic                               w_out_free;
    logic                               w_out_load;
    logic                               w_last_zone;
    logic                               w_last_cam;
    logic                               w_cur_present;
    logic                               w_d_ok;
    logic [zfla_pkg::DEPTH_W-1:0]       w_d_clamp;
    logic [zfla_pkg::DEPTH_W:0]         w_depth2;

    assign o_in_stall  = (r_state != S_IDLE) || r_fres;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_out_load  = w_out_free && (r_fres || (r_state == S_CRES));
    assign w_last_zone = (r_zone == ZW'(ZONES - 1));
    assign w_last_cam  = (r_cam == CW'(CAMERAS - 1));
    assign w_cur_present = r_present_mask[r_cam];

    // Filter and clamp the incoming reading
    assign w_depth2  = {r_depth, 1'b0};
    assign w_d_ok    = (i_in_data.zone_mm != '0) && (r_depth != '0) &&
                       ({1'b0, i_in_data.zone_mm} <= {1'b0, w_depth2});
    assign w_d_clamp = ({1'b0, i_in_data.zone_mm} > {2'b0, r_depth}) ?
                       r_depth : i_in_data.zone_mm[zfla_pkg::DEPTH_W-1:0];

    // Drive the shared divider from the sequencer
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = zfla_pkg::DIV_NW'(r_diff) *
                             zfla_pkg::DIV_NW'(zfla_pkg::FULL_SCALE);
        w_div_req.divisor  = r_depth;
        case (r_state)
            S_MUL: begin
                w_div_req.start = 1'b1;
            end
            S_ZEND: begin
                w_div_req.dividend = zfla_pkg::DIV_NW'(r_cam_sum);
                w_div_req.divisor  = zfla_pkg::DIV_DW'(r_cam_valid);
                w_div_req.start    = w_last_zone && w_cur_present &&
                                     (r_cam_valid != '0);
            end
            S_FSTART: begin
                w_div_req.dividend = zfla_pkg::DIV_NW'(r_frame_sum);
                w_div_req.divisor  = zfla_pkg::DIV_DW'(r_act_cnt);
                w_div_req.start    = (r_act_cnt != '0);
            end
            default: begin
            end
        endcase
    end

    zfla_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Form the camera and summary beats from the running totals
    always_comb begin
        w_cam_beat          = '0;
        w_cam_beat.camera   = zfla_pkg::CAM_W'(r_cam);
        w_cam_beat.fill_x10 = r_fill;
        w_cam_beat.last     = !w_last_cam;
        if (!r_present) begin
            w_cam_beat.health = zfla_pkg::HEALTH_ABSENT;
        end else begin
            w_cam_beat.good_zones = r_cam_valid;
            w_cam_beat.health     = (r_cam_failed || r_cam_valid == '0) ?
                                    zfla_pkg::HEALTH_DEGRADED : zfla_pkg::HEALTH_OK;
        end
        w_sum_beat             = '0;
        w_sum_beat.is_summary  = 1'b1;
        w_sum_beat.fill_x10    = r_fill;
        w_sum_beat.status_mask = r_act_mask;
        w_sum_beat.spread_x10  = (r_act_cnt != '0) ? (r_frame_max - r_frame_min) : '0;
        w_sum_beat.confidence  = zfla_pkg::CONF_W'(r_act_cnt) * zfla_pkg::CONF_PER_CAM;
        w_sum_beat.last        = 1'b1;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth        <= zfla_pkg::DEPTH_RST;
            r_present_mask <= zfla_pkg::PRESENT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                zfla_pkg::REG_DEPTH:   r_depth <= i_cfg_data;
                zfla_pkg::REG_PRESENT: r_present_mask <= i_cfg_data[zfla_pkg::MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fres       <= 1'b0;
            r_zone       <= '0;
            r_cam        <= '0;
            r_cam_sum    <= '0;
            r_cam_valid  <= '0;
            r_cam_failed <= 1'b0;
            r_present    <= 1'b0;
            r_frame_sum  <= '0;
            r_frame_min  <= zfla_pkg::FULL_SCALE;
            r_frame_max  <= '0;
            r_act_cnt    <= '0;
            r_act_mask   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // Drop the output beat once taken, unless a new one loads
            if (r_out_valid && !i_out_stall && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            if (r_fres) begin
                // Issue the frame summary beat and clear the frame
                if (w_out_free) begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= w_sum_beat;
                    r_frame_sum <= '0;
                    r_frame_min <= zfla_pkg::FULL_SCALE;
                    r_frame_max <= '0;
                    r_act_cnt   <= '0;
                    r_act_mask  <= '0;
                    r_fres      <= 1'b0;
                end
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (w_accept) begin
                            if (i_in_data.read_failed) begin
                                r_cam_failed <= 1'b1;
                            end
                            r_diff    <= r_depth - w_d_clamp;
                            r_state   <= w_d_ok ? S_MUL : S_ZEND;
                        end
                    end
                    S_MUL: begin
                        r_state <= S_ZDIV;
                    end
                    S_ZDIV: begin
                        // Accumulate the zone fill
                        if (w_div_rsp.done) begin
                            r_cam_sum   <= r_cam_sum + zfla_pkg::CSUM_W'(w_div_rsp.quotient);
                            r_cam_valid <= r_cam_valid + 1'b1;
                            r_state     <= S_ZEND;
                        end
                    end
                    S_ZEND: begin
                        if (!w_last_zone) begin
                            r_zone  <= r_zone + 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_zone    <= '0;
                            r_present <= w_cur_present;
                            r_fill    <= '0;
                            r_state   <= w_div_req.start ? S_CDIV : S_CRES;
                        end
                    end
                    S_CDIV: begin
                        if (w_div_rsp.done) begin
                            r_fill  <= w_div_rsp.quotient;
                            r_state <= S_CRES;
                        end
                    end
                    S_CRES: begin
                        // Issue the camera beat and fold it into the frame
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= w_cam_beat;
                            if (r_present) begin
                                r_frame_sum <= r_frame_sum + zfla_pkg::FSUM_W'(r_fill);
                                if (r_fill < r_frame_min) begin
                                    r_frame_min <= r_fill;
                                end
                                if (r_fill > r_frame_max) begin
                                    r_frame_max <= r_fill;
                                end
                                r_act_cnt  <= r_act_cnt + 1'b1;
                                r_act_mask <= r_act_mask |
                                              (zfla_pkg::MASK_W'(1) << r_cam);
                            end
                            r_cam_sum    <= '0;
                            r_cam_valid  <= '0;
                            r_cam_failed <= 1'b0;
                            if (w_last_cam) begin
                                r_cam   <= '0;
                                r_state <= S_FSTART;
                            end else begin
                                r_cam   <= r_cam + 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                    end
                    S_FSTART: begin
                        r_fill <= '0;
                        if (r_act_cnt != '0) begin
                            r_state <= S_FDIV;
                        end else begin
                            r_state <= S_IDLE;
                            r_fres  <= 1'b1;
                        end
                    end
                    S_FDIV: begin
                        if (w_div_rsp.done) begin
                            r_fill  <= w_div_rsp.quotient;
                            r_state <= S_IDLE;
                            r_fres  <= 1'b1;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Divider results only land in a state that waits for them
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_ZDIV || r_state == S_CDIV || r_state == S_FDIV))
        else $error("divider result arrived outside a wait state");

    // Every quotient stays within full scale
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (w_div_rsp.quotient <= zfla_pkg::FULL_SCALE))
        else $error("divider quotient above full scale");

    // Frame extremes stay ordered once a camera is counted
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act_cnt != '0) |-> (r_frame_min <= r_frame_max))
        else $error("frame min above frame max");

    // A summary beat always closes the item's results
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.is_summary) |-> r_out_data.last)
        else $error("summary beat without last");

    // Valid zone count never exceeds the zones of one camera
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cam_valid <= zfla_pkg::VALID_W'(ZONES))
        else $error("valid zone count overflow");

endmodule

// File: design/zfla_div.sv
module zfla_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  zfla_pkg::t_div_req i_req,
    output zfla_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [zfla_pkg::DIV_SW-1:0]     r_step;
    logic [zfla_pkg::DIV_NW-1:0]     r_rem;
    logic [zfla_pkg::DIV_NW-1:0]     r_dsh;
    logic [zfla_pkg::DIV_QW-1:0]     r_quo;
    logic                            w_fit;

    // Trial compare of the remainder against the shifted divisor
    assign w_fit = (r_rem >= r_dsh);

    // Control: one quotient bit per cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= zfla_pkg::DIV_SW'(zfla_pkg::DIV_QW - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // Datapath: restoring subtract and shift
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dsh <= zfla_pkg::DIV_NW'({i_req.divisor, {(zfla_pkg::DIV_QW-1){1'b0}}});
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[zfla_pkg::DIV_QW-2:0], w_fit};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
